[rtl/tmpl_pkg.sv]
// Package for the tiled map pixel lookup: store sizes, address widths,
// item codes and the coordinate decode record. No dependencies.
package tmpl_pkg;

    // Store sizes
    localparam int MAP_ENTRIES   = 16384;
    localparam int TILE_COUNT    = 1024;
    localparam int TILE_BYTES    = 64;
    localparam int PAL_DEPTH     = 256;
    localparam int TILE_STORE    = TILE_COUNT * TILE_BYTES;

    // Address widths
    localparam int MAP_AW        = $clog2(MAP_ENTRIES);
    localparam int TILE_NW       = $clog2(TILE_COUNT);
    localparam int TILE_AW       = $clog2(TILE_STORE);
    localparam int PAL_AW        = $clog2(PAL_DEPTH);

    // Field widths
    localparam int CMD_W         = 2;
    localparam int POS_W         = 16;
    localparam int ADDR_W        = 16;
    localparam int DATA_W        = 16;
    localparam int DIM_W         = 13;
    localparam int TNUM_W        = 10;
    localparam int PIX_W         = 8;
    localparam int COL_W         = 16;
    localparam int OFF_W         = 6;
    localparam int BLK_W         = 10;
    localparam int ENTRY_W       = 20;
    localparam int CFG_IDX_W     = 1;

    // Reset values of the configuration registers
    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(256);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP  = 2'd0,
        CMD_WR_MAP  = 2'd1,
        CMD_WR_TILE = 2'd2,
        CMD_WR_PAL  = 2'd3
    } t_cmd;

    // Decoded lookup coordinates
    typedef struct packed {
        logic                in_range;
        logic                entry_ok;
        logic [MAP_AW-1:0]   map_addr;
        logic [OFF_W-1:0]    pix_off;
    } t_coord;

endpackage

[rtl/tmpl_coord.sv]
// Coordinate decode for the tiled map pixel lookup: bounds check, map
// entry address and pixel offset within a tile. Depends on tmpl_pkg.
module tmpl_coord (
    input  logic [tmpl_pkg::POS_W-1:0]  i_pos_x,
    input  logic [tmpl_pkg::POS_W-1:0]  i_pos_y,
    input  logic [tmpl_pkg::DIM_W-1:0]  i_map_width,
    input  logic [tmpl_pkg::DIM_W-1:0]  i_map_height,
    output tmpl_pkg::t_coord            o_coord
);

    logic                          w_x_ok;
    logic                          w_y_ok;
    logic [tmpl_pkg::BLK_W-1:0]    w_row_base;
    logic [tmpl_pkg::BLK_W-1:0]    w_blk;
    logic [tmpl_pkg::ENTRY_W-1:0]  w_entry;

    // negative coordinates carry bit 15
    assign w_x_ok = !i_pos_x[tmpl_pkg::POS_W-1]
                 && (i_pos_x < tmpl_pkg::POS_W'(i_map_width));
    assign w_y_ok = !i_pos_y[tmpl_pkg::POS_W-1]
                 && (i_pos_y < tmpl_pkg::POS_W'(i_map_height));

    // block index: row of blocks times blocks per row, plus block column
    assign w_row_base = tmpl_pkg::BLK_W'(i_pos_y[12:8] * i_map_width[12:8]);
    assign w_blk      = w_row_base + tmpl_pkg::BLK_W'(i_pos_x[12:8]);
    assign w_entry    = {w_blk, i_pos_y[7:3], i_pos_x[7:3]};

    assign o_coord.in_range = w_x_ok && w_y_ok;
    assign o_coord.entry_ok = (w_entry < tmpl_pkg::ENTRY_W'(tmpl_pkg::MAP_ENTRIES));
    assign o_coord.map_addr = w_entry[tmpl_pkg::MAP_AW-1:0];
    assign o_coord.pix_off  = {i_pos_y[2:0], i_pos_x[2:0]};

endmodule

[rtl/tiled_map_pixel_lookup.sv]
// Top level of the tiled 8bpp map pixel lookup: four-stage pipeline with the
// map, tile and palette stores. Depends on tmpl_pkg and tmpl_coord.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------------
//  in       | to block  | i_valid / o_stall  | i_cmd, i_pos_x, i_pos_y,
//           |           |                    | i_store_addr, i_store_data
//  out      | from blk  | o_valid / i_stall  | o_in_range, o_tile_number,
//           |           |                    | o_pal_index, o_color
//  cfg      | to block  | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// One transaction enters per cycle while o_stall is low; a lookup result passes
// through stages 1 to 4, which hold the chain of three registered store reads.
// Each stage loads whenever it is empty or the stage after it moves, so
// bubbles close up; a held result stalls the input only once all four stages are full.
// Reset (synchronous) empties the pipeline and sets both dimensions to 256;
// store contents stay undefined until written. No clearing pass is needed.
module tiled_map_pixel_lookup (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [tmpl_pkg::CMD_W-1:0]      i_cmd,
    input  logic signed [tmpl_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [tmpl_pkg::POS_W-1:0] i_pos_y,
    input  logic [tmpl_pkg::ADDR_W-1:0]     i_store_addr,
    input  logic [tmpl_pkg::DATA_W-1:0]     i_store_data,
    // output channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_in_range,
    output logic [tmpl_pkg::TNUM_W-1:0]     o_tile_number,
    output logic [tmpl_pkg::PIX_W-1:0]      o_pal_index,
    output logic [tmpl_pkg::COL_W-1:0]      o_color,
    // configuration port
    input  logic                            i_cfg_we,
    input  logic [tmpl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tmpl_pkg::DIM_W-1:0]      i_cfg_data
);

    // ------------------------------------------------------------------
    // Stores
    // ------------------------------------------------------------------
    logic [tmpl_pkg::TNUM_W-1:0] r_tile_map    [tmpl_pkg::MAP_ENTRIES];
    logic [tmpl_pkg::PIX_W-1:0]  r_tile_pixels [tmpl_pkg::TILE_STORE];
    logic [tmpl_pkg::COL_W-1:0]  r_palette     [tmpl_pkg::PAL_DEPTH];

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [tmpl_pkg::DIM_W-1:0]  r_map_width;
    logic [tmpl_pkg::DIM_W-1:0]  r_map_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= tmpl_pkg::DIM_RESET;
            r_map_height <= tmpl_pkg::DIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tmpl_pkg::CFG_MAP_WIDTH:  r_map_width  <= i_cfg_data;
                tmpl_pkg::CFG_MAP_HEIGHT: r_map_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage enables: a stage loads when empty or when its successor loads
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_en1, w_en2, w_en3, w_en4;

    assign w_en4   = !r_v4 || !i_stall;
    assign w_en3   = !r_v3 || w_en4;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_stall = !w_en1;

    // ------------------------------------------------------------------
    // Stage 0 -> 1: decode coordinates
    // ------------------------------------------------------------------
    tmpl_pkg::t_coord w_coord;

    tmpl_coord u_coord (
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_map_width  (r_map_width),
        .i_map_height (r_map_height),
        .o_coord      (w_coord)
    );

    tmpl_pkg::t_cmd                  r_cmd1;
    tmpl_pkg::t_coord                r_coord1;
    logic [tmpl_pkg::ADDR_W-1:0]     r_addr1;
    logic [tmpl_pkg::DATA_W-1:0]     r_data1;

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_cmd1   <= tmpl_pkg::t_cmd'(i_cmd);
            r_coord1 <= w_coord;
            r_addr1  <= i_store_addr;
            r_data1  <= i_store_data;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 -> 2: map store access (write a map entry, or read tile number)
    // ------------------------------------------------------------------
    logic w_map_wr;

    assign w_map_wr = r_v1 && (r_cmd1 == tmpl_pkg::CMD_WR_MAP)
                   && ({1'b0, r_addr1} < (tmpl_pkg::ADDR_W+1)'(tmpl_pkg::MAP_ENTRIES));

    tmpl_pkg::t_cmd                  r_cmd2;
    logic                            r_inr2;
    logic                            r_entok2;
    logic [tmpl_pkg::OFF_W-1:0]      r_off2;
    logic [tmpl_pkg::ADDR_W-1:0]     r_addr2;
    logic [tmpl_pkg::DATA_W-1:0]     r_data2;
    logic [tmpl_pkg::TNUM_W-1:0]     r_map_q2;

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_cmd2   <= r_cmd1;
            r_inr2   <= r_coord1.in_range;
            r_entok2 <= r_coord1.entry_ok;
            r_off2   <= r_coord1.pix_off;
            r_addr2  <= r_addr1;
            r_data2  <= r_data1;
            r_map_q2 <= r_tile_map[r_coord1.map_addr];
            if (w_map_wr) begin
                r_tile_map[r_addr1[tmpl_pkg::MAP_AW-1:0]] <= r_data1[tmpl_pkg::TNUM_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2 -> 3: tile store access (write a tile byte, or read the pixel)
    // ------------------------------------------------------------------
    logic [tmpl_pkg::TNUM_W-1:0]     w_tile2;
    logic                            w_tile_ok2;
    logic [tmpl_pkg::TILE_AW-1:0]    w_pix_addr2;
    logic                            w_tile_wr;

    // an entry beyond the map store reads tile zero; out of range clears all
    assign w_tile2     = (r_inr2 && r_entok2) ? r_map_q2 : '0;
    assign w_tile_ok2  = ({1'b0, w_tile2} < (tmpl_pkg::TNUM_W+1)'(tmpl_pkg::TILE_COUNT));
    assign w_pix_addr2 = {w_tile2[tmpl_pkg::TILE_NW-1:0], r_off2};
    assign w_tile_wr   = r_v2 && (r_cmd2 == tmpl_pkg::CMD_WR_TILE)
                      && ({1'b0, r_addr2} < (tmpl_pkg::ADDR_W+1)'(tmpl_pkg::TILE_STORE));

    tmpl_pkg::t_cmd                  r_cmd3;
    logic                            r_inr3;
    logic                            r_tok3;
    logic [tmpl_pkg::TNUM_W-1:0]     r_tile3;
    logic [tmpl_pkg::ADDR_W-1:0]     r_addr3;
    logic [tmpl_pkg::DATA_W-1:0]     r_data3;
    logic [tmpl_pkg::PIX_W-1:0]      r_pix_q3;

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_cmd3   <= r_cmd2;
            r_inr3   <= r_inr2;
            r_tok3   <= w_tile_ok2;
            r_tile3  <= w_tile2;
            r_addr3  <= r_addr2;
            r_data3  <= r_data2;
            r_pix_q3 <= r_tile_pixels[w_pix_addr2];
            if (w_tile_wr) begin
                r_tile_pixels[r_addr2[tmpl_pkg::TILE_AW-1:0]] <= r_data2[tmpl_pkg::PIX_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3 -> 4: palette access (write a colour, or read it); result out
    // ------------------------------------------------------------------
    logic [tmpl_pkg::PIX_W-1:0]      w_pix3;
    logic                            w_pal_wr;

    // a tile beyond the tile store reads index zero
    assign w_pix3   = (r_inr3 && r_tok3) ? r_pix_q3 : '0;
    assign w_pal_wr = r_v3 && (r_cmd3 == tmpl_pkg::CMD_WR_PAL)
                   && ({1'b0, r_addr3} < (tmpl_pkg::ADDR_W+1)'(tmpl_pkg::PAL_DEPTH));

    logic                            r_inr4;
    logic [tmpl_pkg::TNUM_W-1:0]     r_tile4;
    logic [tmpl_pkg::PIX_W-1:0]      r_pix4;
    logic [tmpl_pkg::COL_W-1:0]      r_col_q4;

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_inr4   <= r_inr3;
            r_tile4  <= r_tile3;
            r_pix4   <= w_pix3;
            r_col_q4 <= r_palette[w_pix3[tmpl_pkg::PAL_AW-1:0]];
            if (w_pal_wr) begin
                r_palette[r_addr3[tmpl_pkg::PAL_AW-1:0]] <= r_data3;
            end
        end
    end

    // ------------------------------------------------------------------
    // Valid bits: writes drop out after the palette stage, lookups go on
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
            if (w_en4) begin
                r_v4 <= r_v3 && (r_cmd3 == tmpl_pkg::CMD_LOOKUP);
            end
        end
    end

    // zero the colour of a lookup outside the map
    assign o_valid       = r_v4;
    assign o_in_range    = r_inr4;
    assign o_tile_number = r_tile4;
    assign o_pal_index   = r_pix4;
    assign o_color       = r_inr4 ? r_col_q4 : '0;

endmodule
